### src/sar_pkg.sv
// package for the socket address registry
// shared constants, types and the controller state encoding
// no dependencies
package sar_pkg;

	localparam int TableDepth = 1024;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int KeyW = 48;
	localparam int OwnerW = 16;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FAIL  = 3'd1,
		ST_ERR   = 3'd2,
		ST_FOUND = 3'd3,
		ST_FULL  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_PARSE,
		S_SCAN,
		S_WAIT,
		S_DONE,
		S_OUT
	} state_t;

	localparam logic [7:0] ChDot   = 8'h2e;
	localparam logic [7:0] ChColon = 8'h3a;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	// controller -> datapath
	typedef struct packed {
		logic take_char;  // consume one character
		logic finish;     // close string, latch key and request number
		logic scan_start; // reset scan pointer
		logic scan_step;  // issue read at scan pointer, advance
		logic write;      // store key at free slot
		logic out_load;   // load result register
	} sar_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ok;        // latched string was well formed
		logic scan_last; // pointer is at last entry
	} sar_sts_t;

endpackage

### src/sar_ctrl.sv
// controller state machine for the socket address registry
// depends on sar_pkg
module sar_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	input  logic              out_busy,
	input  sar_pkg::sar_sts_t sts,
	output logic              in_ready,
	output sar_pkg::sar_cmd_t cmd
);

	sar_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sar_pkg::S_PARSE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			sar_pkg::S_PARSE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_char = 1'b1;
					if (in_last) begin
						cmd.finish = 1'b1;
						state_d = sar_pkg::S_SCAN;
					end
				end
			end
			sar_pkg::S_SCAN: begin
				if (!sts.ok) begin
					state_d = sar_pkg::S_OUT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = sar_pkg::S_WAIT;
				end
			end
			sar_pkg::S_WAIT: begin
				// one read per cycle, compare runs in the cycle after its read
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = sar_pkg::S_DONE;
				end
			end
			sar_pkg::S_DONE: begin
				// last compare lands this cycle
				state_d = sar_pkg::S_OUT;
			end
			sar_pkg::S_OUT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					cmd.write = 1'b1;
					state_d = sar_pkg::S_PARSE;
				end
			end
			default: state_d = sar_pkg::S_PARSE;
		endcase
	end

endmodule

### src/sar_dp.sv
// datapath: character parser, key table and result register
// depends on sar_pkg
module sar_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_func,
	input  logic [7:0]        in_ch,
	input  sar_pkg::sar_cmd_t cmd,
	input  logic              out_ready,
	output sar_pkg::sar_sts_t sts,
	output logic              out_valid,
	output logic              out_busy,
	output logic [2:0]        out_status,
	output logic [15:0]       out_owner
);

	// parse state
	logic [2:0]  fidx_q;
	logic [16:0] fval_q;
	logic [2:0]  dcnt_q;
	logic        lz_q, perr_q;
	logic [31:0] acc_q;
	logic [15:0] req_q;

	// latched request
	logic        ok_q, func_q;
	logic [47:0] key_q;

	logic [2:0]  fidx_n;
	logic [16:0] fval_n;
	logic [2:0]  dcnt_n;
	logic        lz_n, perr_n;
	logic [31:0] acc_n;
	logic [19:0] mul;
	logic [3:0]  dig;
	logic        port;

	always_comb begin
		fidx_n = fidx_q; fval_n = fval_q; dcnt_n = dcnt_q;
		lz_n = lz_q; perr_n = perr_q; acc_n = acc_q;
		dig = 4'(in_ch - sar_pkg::ChZero);
		port = (fidx_q == 3'd4);
		mul = 20'(fval_q) * 20'd10 + 20'(dig);
		if (!perr_q) begin
			if (in_ch >= sar_pkg::ChZero && in_ch <= sar_pkg::ChNine) begin
				if (dcnt_q != 3'd0 && lz_q) perr_n = 1'b1;
				if (dcnt_q == 3'd0 && dig == 4'd0) lz_n = 1'b1;
				if (dcnt_q < 3'd7) dcnt_n = dcnt_q + 3'd1;
				fval_n = (mul > 20'd65536) ? 17'd65536 : mul[16:0];
				if (dcnt_n > (port ? 3'd5 : 3'd3)
					|| fval_n > (port ? 17'd65535 : 17'd255)) perr_n = 1'b1;
			end else if ((in_ch == sar_pkg::ChDot && fidx_q < 3'd3)
				|| (in_ch == sar_pkg::ChColon && fidx_q == 3'd3)) begin
				if (dcnt_q == 3'd0) perr_n = 1'b1;
				acc_n = {acc_q[23:0], fval_q[7:0]};
				fidx_n = fidx_q + 3'd1;
				fval_n = '0; dcnt_n = '0; lz_n = 1'b0;
			end else begin
				perr_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q <= '0; fval_q <= '0; dcnt_q <= '0;
			lz_q <= 1'b0; perr_q <= 1'b0; acc_q <= '0;
			req_q <= '0; ok_q <= 1'b0; func_q <= 1'b0;
		end else if (cmd.finish) begin
			fidx_q <= '0; fval_q <= '0; dcnt_q <= '0;
			lz_q <= 1'b0; perr_q <= 1'b0; acc_q <= '0;
			if (req_q != 16'hffff) req_q <= req_q + 16'd1;
			ok_q <= !perr_n && fidx_n == 3'd4 && dcnt_n != 3'd0;
			func_q <= in_func;
		end else if (cmd.take_char) begin
			fidx_q <= fidx_n; fval_q <= fval_n; dcnt_q <= dcnt_n;
			lz_q <= lz_n; perr_q <= perr_n; acc_q <= acc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) key_q <= {acc_n, fval_n[15:0]};
	end

	// key table, entries are only ever appended so a fill count marks the
	// used prefix; the count is cleared at reset
	logic [sar_pkg::CntW-1:0] fill_q;
	logic [47:0] key_mem [sar_pkg::TableDepth];
	logic [15:0] own_mem [sar_pkg::TableDepth];
	logic [47:0] rkey_q;
	logic [15:0] rown_q;
	logic        rvld_q, ract_q;
	logic [sar_pkg::IdxW-1:0] ptr_q, rptr_q, free_q;
	logic        hit_q, freefound_q;
	logic [15:0] hown_q;

	always_ff @(posedge clk) begin
		if (cmd.write && ok_q && !func_q && !hit_q && freefound_q) begin
			key_mem[free_q] <= key_q;
			own_mem[free_q] <= req_q;
		end
		rkey_q <= key_mem[ptr_q];
		rown_q <= own_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0; ptr_q <= '0; rptr_q <= '0; rvld_q <= 1'b0;
			ract_q <= 1'b0; hit_q <= 1'b0; freefound_q <= 1'b0;
			free_q <= '0; hown_q <= '0;
		end else begin
			ract_q <= cmd.scan_step;
			rptr_q <= ptr_q;
			rvld_q <= ({1'b0, ptr_q} < fill_q);
			if (cmd.scan_start) begin
				ptr_q <= '0; hit_q <= 1'b0; freefound_q <= 1'b0;
			end else if (cmd.scan_step) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (ract_q) begin
				if (rvld_q) begin
					if (!hit_q && rkey_q == key_q) begin
						hit_q <= 1'b1; hown_q <= rown_q;
					end
				end else if (!freefound_q) begin
					freefound_q <= 1'b1; free_q <= rptr_q;
				end
			end
			if (cmd.write && ok_q && !func_q && !hit_q && freefound_q)
				fill_q <= fill_q + 1'b1;
		end
	end

	assign sts.ok = ok_q;
	assign sts.scan_last = (ptr_q == sar_pkg::IdxW'(sar_pkg::TableDepth - 1));

	// result register
	logic [2:0]  st_d;
	logic [15:0] ow_d;
	always_comb begin
		ow_d = '0;
		if (!ok_q) st_d = sar_pkg::ST_ERR;
		else if (func_q) begin
			if (hit_q) begin st_d = sar_pkg::ST_FOUND; ow_d = hown_q; end
			else st_d = sar_pkg::ST_FAIL;
		end else if (hit_q) st_d = sar_pkg::ST_FAIL;
		else if (!freefound_q) st_d = sar_pkg::ST_FULL;
		else st_d = sar_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= st_d; out_owner <= ow_d;
		end
	end

	assign out_busy = out_valid && !out_ready;

	a_found_has_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && st_d == sar_pkg::ST_FOUND |-> hit_q && func_q)
		else $error("found without hit");
	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && !ok_q |=> $stable(fill_q))
		else $error("malformed string wrote table");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_busy)
		else $error("result overwritten");

endmodule

### src/socket_address_registry.sv
// socket address registry top level: parses a.b.c.d:e text and
// registers or looks up the packed key; depends on sar_pkg, sar_ctrl, sar_dp
// characters are parsed one per cycle; after the last character a full table
// scan (one memory read per cycle), then the result once the output is free
// strings are handled one at a time, the next only after the result loads
// reset: arst_n clears the request counter, parser and the table fill count
module socket_address_registry (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch[7:0]
	input  logic        s_tuser,   // func
	input  logic        s_tlast,   // last character of a string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // status[2:0], owner_number[18:3], zero pad
);

	sar_pkg::sar_cmd_t cmd;
	sar_pkg::sar_sts_t sts;
	logic              busy;
	logic [2:0]        st;
	logic [15:0]       own;

	// controller sequences parse, scan and result
	sar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.out_busy (busy),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	// datapath holds parser, table and the output word register
	sar_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_func    (s_tuser),
		.in_ch      (s_tdata),
		.cmd        (cmd),
		.out_ready  (m_tready),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_busy   (busy),
		.out_status (st),
		.out_owner  (own)
	);

	assign m_tdata = {5'd0, own, st};

endmodule

### dv/socket_address_registry_tb.sv
// testbench for the socket address registry: streams address text words,
// predicts each string's status and owner, and checks every result word
// depends on sar_pkg and socket_address_registry
`timescale 1ns / 1ps

module socket_address_registry_tb;

	typedef struct packed {
		logic       func;
		logic [7:0] ch;
		logic       last;
	} char_word_t;

	typedef struct packed {
		sar_pkg::status_t status;
		logic [15:0]      owner;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // ch[7:0]
	logic        s_tuser;   // func
	logic        s_tlast;   // last character of a string
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // status[2:0], owner_number[18:3], zero pad

	socket_address_registry i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// stimulus and expectations
	char_word_t pending_chars[$];
	reply_t     expected_replies[$];
	int         mismatches = 0;
	int         strings_done = 0;
	bit         quiet_phase;    // no idling near the end
	bit         sink_hold;      // long receiver hold-off request
	bit         source_pause;   // sender waits for drain
	int         sink_gap = 0;
	int         source_gap = 0;
	bit         s_tready_seen;  // handshake seen at the last rising edge

	// predictor state
	logic [15:0] req_count = '0;
	logic [2:0]  fld_idx = '0;
	logic [16:0] fld_val = '0;
	logic [2:0]  dig_cnt = '0;
	logic        lead_zero = 1'b0;
	logic        bad = 1'b0;
	logic [31:0] addr_acc = '0;
	logic        slot_used[sar_pkg::TableDepth] = '{default: 1'b0};
	logic [47:0] slot_key[sar_pkg::TableDepth];
	logic [15:0] slot_owner[sar_pkg::TableDepth];

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// close an octet field into the address accumulator
	function automatic void fold_octet();
		if (dig_cnt == 0) bad = 1;
		addr_acc = {addr_acc[23:0], fld_val[7:0]};
		fld_idx++;
		fld_val = 0;
		dig_cnt = 0;
		lead_zero = 0;
	endfunction

	// advance the parser by one character, return a reply on string end
	function automatic bit parse_char(char_word_t w, output reply_t r);
		logic [47:0] key;
		bit          well_formed;
		int          hit_slot;
		int          free_slot;
		int          digit;
		int          val;
		r = '0;
		if (!bad) begin
			if (w.ch >= sar_pkg::ChZero && w.ch <= sar_pkg::ChNine) begin
				digit = w.ch - sar_pkg::ChZero;
				if (dig_cnt >= 1 && lead_zero) bad = 1;
				if (dig_cnt == 0 && digit == 0) lead_zero = 1;
				if (dig_cnt < 7) dig_cnt++;
				val = fld_val * 10 + digit;
				if (val > 65536) val = 65536;
				fld_val = 17'(val);
				if (fld_idx == 4) begin
					if (dig_cnt > 5 || val > 65535) bad = 1;
				end else if (dig_cnt > 3 || val > 255) begin
					bad = 1;
				end
			end else if (w.ch == sar_pkg::ChDot) begin
				if (fld_idx < 3) fold_octet();
				else bad = 1;
			end else if (w.ch == sar_pkg::ChColon) begin
				if (fld_idx == 3) fold_octet();
				else bad = 1;
			end else begin
				bad = 1;
			end
		end
		if (!w.last) return 0;
		if (req_count != 16'hffff) req_count++;
		well_formed = !bad && fld_idx == 4 && dig_cnt != 0;
		key = {addr_acc, fld_val[15:0]};
		fld_idx = 0; fld_val = 0; dig_cnt = 0; lead_zero = 0; bad = 0; addr_acc = 0;
		if (!well_formed) begin
			r.status = sar_pkg::ST_ERR;
			return 1;
		end
		hit_slot = -1;
		free_slot = -1;
		for (int i = 0; i < sar_pkg::TableDepth; i++) begin
			if (slot_used[i]) begin
				if (hit_slot < 0 && slot_key[i] == key) hit_slot = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (!w.func) begin
			if (hit_slot >= 0) r.status = sar_pkg::ST_FAIL;
			else if (free_slot < 0) r.status = sar_pkg::ST_FULL;
			else begin
				slot_used[free_slot] = 1;
				slot_key[free_slot] = key;
				slot_owner[free_slot] = req_count;
				r.status = sar_pkg::ST_OK;
			end
		end else if (hit_slot >= 0) begin
			r.status = sar_pkg::ST_FOUND;
			r.owner = slot_owner[hit_slot];
		end else begin
			r.status = sar_pkg::ST_FAIL;
		end
		return 1;
	endfunction

	// queue one string as character words; func sits on the last word, the others carry random func bits
	task automatic push_text(string s, bit func);
		char_word_t w;
		for (int i = 0; i < s.len(); i++) begin
			w.func = (i == s.len() - 1) ? func : 1'($urandom);
			w.ch = s[i];
			w.last = (i == s.len() - 1);
			pending_chars.push_back(w);
		end
	endtask

	function automatic string rand_addr(int pool);
		// small pools make repeats, so lookups hit and registers collide
		if (pool > 0)
			return $sformatf("10.%0d.%0d.%0d:%0d", $urandom_range(0, 1),
				$urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, pool));
		return $sformatf("%0d.%0d.%0d.%0d:%0d", $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 65535));
	endfunction

	// corrupt a good string in one of several ways
	function automatic string break_addr(string s);
		int    p;
		string t;
		p = $urandom_range(0, s.len() - 1);
		t = s;
		case ($urandom_range(0, 5))
			0: t[p] = 8'($urandom);
			1: t = {s.substr(0, p), "0", s.substr(p + 1, s.len() - 1)};
			2: t = s.substr(0, p);
			3: t = {s, ".1"};
			4: t = {s, "9"};
			default: t = {s.substr(0, p), ":", s.substr(p + 1, s.len() - 1)};
		endcase
		return t;
	endfunction

	// driver: new word at the falling edge, head of queue stays until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			s_tuser <= 0;
			s_tlast <= 0;
		end else begin
			if (s_tvalid && s_tready_seen && pending_chars.size() > 0)
				void'(pending_chars.pop_front());
			if (source_gap > 0) begin
				source_gap--;
				s_tvalid <= 0;
			end else if (source_pause && expected_replies.size() != 0 &&
					(!s_tvalid || s_tready_seen)) begin
				s_tvalid <= 0;
			end else if ((!s_tvalid || s_tready_seen) && !quiet_phase &&
					$urandom_range(0, 9) == 0) begin
				source_gap = $urandom_range(0, 3);
				s_tvalid <= 0;
			end else if (pending_chars.size() > 0) begin
				s_tvalid <= 1;
				{s_tuser, s_tdata, s_tlast} <= pending_chars[0];
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// monitor: predict on accepted words, check result words
	always @(posedge clk) begin
		reply_t r;
		reply_t want;
		s_tready_seen <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			if (parse_char({s_tuser, s_tdata, s_tlast}, r)) expected_replies.push_back(r);
		end
		if (m_tvalid && m_tready) begin
			strings_done++;
			r.status = sar_pkg::status_t'(m_tdata[2:0]);
			r.owner = m_tdata[18:3];
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
			end else begin
				want = expected_replies.pop_front();
				if (r.status != want.status || r.owner != want.owner ||
						m_tdata[23:19] != 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: word %h status %0d owner %0d, expected %0d owner %0d",
							m_tdata, r.status, r.owner, want.status, want.owner);
				end
			end
		end
	end

	// receiver stalls in short bursts, or one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else if (sink_hold) begin
			m_tready <= 0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 0;
		end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			sink_gap = $urandom_range(0, 3);
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	// long hold-off, counted in its own process
	initial begin
		sink_hold = 0;
		wait (strings_done >= 20);
		sink_hold = 1;
		repeat (3000) @(posedge clk);
		sink_hold = 0;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		string s;
		int    n;
		bit    paused;
		arst_n = 0;
		quiet_phase = 0;
		source_pause = 0;
		paused = 0;

		// directed: extremes, both kinds, each rejection rule
		push_text("0.0.0.0:0", 0);
		push_text("255.255.255.255:65535", 0);
		push_text("255.255.255.255:65535", 0);   // duplicate register
		push_text("255.255.255.255:65535", 1);   // found
		push_text("1.2.3.4:5", 1);               // lookup miss
		push_text("256.0.0.0:1", 0);             // octet too big
		push_text("1.2.3.4:65536", 0);           // port too big
		push_text("01.2.3.4:5", 1);              // leading zero
		push_text("1.2.3.4:000001", 0);          // long digit run with leading zeros
		push_text("1.2.3:4.5", 0);               // colon out of order
		push_text("1..3.4:5", 0);                // empty octet
		push_text("1.2.3.4:", 1);                // empty port
		push_text("1.2.3.4.5:6", 0);             // extra dot
		push_text("1.2.3.4:5:6", 0);             // extra colon
		push_text("1.2.3.4:5a", 1);              // junk after colon
		push_text("\xff", 0);
		push_text("\x80\x7f.1.1.1:1", 0);

		#1;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// random strings, mostly well formed
		n = 0;
		while (n < 1600) begin
			case ($urandom_range(0, 9))
				0, 1: s = break_addr(rand_addr(0));
				2: s = rand_addr(0);
				default: s = rand_addr(40);
			endcase
			push_text(s, $urandom_range(0, 2) == 0 ? 0 : 1);
			n += s.len();
			if (n > 1300) quiet_phase = 1;
			if (strings_done > 60 && !paused) begin
				paused = 1;
				source_pause = 1;
				wait (pending_chars.size() == 0 && expected_replies.size() == 0);
				source_pause = 0;
			end
			wait (pending_chars.size() < 40);
		end
		push_text("255.255.255.255:65535", 1);

		wait (pending_chars.size() == 0 && expected_replies.size() == 0);
		repeat (sar_pkg::TableDepth + 50) @(posedge clk);
		if (mismatches == 0 && expected_replies.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
